### sv/fbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_pkg
// Shared types, widths and helpers for the frustum box culler.
// ----------------------------------------------------------------------------
package fbc_pkg;

	localparam int ELEM_W        = 32;
	localparam int CLIP_W        = 40;
	localparam int COEF_W        = 41;
	localparam int PSTORE_W      = 42;
	localparam int ACC_W         = 66;
	localparam int SUM_W         = 75;
	localparam int MAT_DEPTH     = 16;
	localparam int PLANE_COEFFS  = 24;
	localparam int NUM_PLANES    = 6;
	localparam int FRAC_BITS_DEF = 16;

	localparam logic signed [ACC_W-1:0] CLIP_MAX = ACC_W'(64'sh7F_FFFF_FFFF);
	localparam logic signed [ACC_W-1:0] CLIP_MIN = -CLIP_MAX - ACC_W'(1);

	typedef enum logic [1:0] {
		OP_LOAD_MV = 2'd0,
		OP_LOAD_PJ = 2'd1,
		OP_EXTRACT = 2'd2,
		OP_TEST    = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EX_RUN,
		ST_EX_DRAIN,
		ST_EX_WRITE,
		ST_BOX_RUN,
		ST_BOX_DRAIN,
		ST_BOX_DONE
	} state_t;

	typedef struct packed {
		logic signed [ELEM_W-1:0] x_min;
		logic signed [ELEM_W-1:0] y_min;
		logic signed [ELEM_W-1:0] z_min;
		logic signed [ELEM_W-1:0] x_max;
		logic signed [ELEM_W-1:0] y_max;
		logic signed [ELEM_W-1:0] z_max;
	} box_t;

	typedef struct packed {
		logic                     valid;
		logic [1:0]               k;
		logic                     last;
		logic signed [COEF_W-1:0] coef;
	} coef_tag_t;

	typedef struct packed {
		logic valid;
		logic last;
		logic culled;
	} plane_res_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] c;
		logic [1:0] k;
	} ex_tag_t;

	// column of the clip matrix combined with column 3 for each plane
	function automatic logic [1:0] plane_col(input logic [2:0] p);
		return p[2:1];
	endfunction

	// right, left, bottom, top, far, near: subtract or add
	function automatic logic plane_add(input logic [2:0] p);
		logic r;
		case (p)
			3'd1, 3'd2, 3'd5: r = 1'b1;
			default:          r = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic signed [CLIP_W-1:0] sat_clip(input logic signed [ACC_W-1:0] v);
		logic signed [CLIP_W-1:0] r;
		if (v > CLIP_MAX) r = CLIP_MAX[CLIP_W-1:0];
		else if (v < CLIP_MIN) r = CLIP_MIN[CLIP_W-1:0];
		else r = v[CLIP_W-1:0];
		return r;
	endfunction

endpackage
`default_nettype wire

### sv/fbc_in_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_in_if
// Input channel: matrix loads, plane extraction and box tests.
// ----------------------------------------------------------------------------
interface fbc_in_if;
	logic               valid;
	logic               ready;
	logic [1:0]         op;
	logic [3:0]         elem_index;
	logic signed [31:0] elem_value;
	logic signed [31:0] box_x_min;
	logic signed [31:0] box_y_min;
	logic signed [31:0] box_z_min;
	logic signed [31:0] box_x_max;
	logic signed [31:0] box_y_max;
	logic signed [31:0] box_z_max;

	modport source(output valid, op, elem_index, elem_value, box_x_min, box_y_min,
		box_z_min, box_x_max, box_y_max, box_z_max, input ready);
	modport sink(input valid, op, elem_index, elem_value, box_x_min, box_y_min,
		box_z_min, box_x_max, box_y_max, box_z_max, output ready);
endinterface
`default_nettype wire

### sv/fbc_out_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_out_if
// Result channel: one visibility bit per box test.
// ----------------------------------------------------------------------------
interface fbc_out_if;
	logic valid;
	logic ready;
	logic visible;

	modport source(output valid, visible, input ready);
	modport sink(input valid, visible, output ready);
endinterface
`default_nettype wire

### sv/fbc_box_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// fbc_box_mac
// Plane distance unit: per axis the larger of coef*min and coef*max, summed
// with d; flags the plane when that sum is <= 0 and an axis coef is nonzero.
// ----------------------------------------------------------------------------
module fbc_box_mac #(
	parameter int FRAC_BITS = fbc_pkg::FRAC_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fbc_pkg::coef_tag_t    tag_s1,
	input  fbc_pkg::box_t         box,
	output fbc_pkg::plane_res_t   res
);
	import fbc_pkg::*;

	logic signed [ELEM_W-1:0]  mn, mx;
	logic signed [ELEM_W:0]    c_lo;
	logic signed [8:0]         c_hi;

	coef_tag_t                 tag_s2, tag_s3;
	logic signed [64:0]        lo_mn_s2, lo_mx_s2;
	logic signed [40:0]        hi_mn_s2, hi_mx_s2;
	logic signed [SUM_W-1:0]   p_mn, p_mx, term;
	logic signed [SUM_W-1:0]   term_s3;
	logic                      nz_s3;
	logic signed [SUM_W-1:0]   acc_q, sum;
	logic                      nz_q, nz_sum;

	always_comb begin
		case (tag_s1.k)
			2'd0:    begin mn = box.x_min; mx = box.x_max; end
			2'd1:    begin mn = box.y_min; mx = box.y_max; end
			default: begin mn = box.z_min; mx = box.z_max; end
		endcase
		c_lo = {1'b0, tag_s1.coef[31:0]};
		c_hi = tag_s1.coef[COEF_W-1:32];
	end

	// split multiply: upper nine bits and lower 32 bits of the coefficient
	always_ff @(posedge clk) begin
		lo_mn_s2 <= c_lo * mn;
		lo_mx_s2 <= c_lo * mx;
		hi_mn_s2 <= c_hi * mn;
		hi_mx_s2 <= c_hi * mx;
	end

	always_comb begin
		p_mn = ({{(SUM_W-41){hi_mn_s2[40]}}, hi_mn_s2} <<< 32)
			+ {{(SUM_W-65){lo_mn_s2[64]}}, lo_mn_s2};
		p_mx = ({{(SUM_W-41){hi_mx_s2[40]}}, hi_mx_s2} <<< 32)
			+ {{(SUM_W-65){lo_mx_s2[64]}}, lo_mx_s2};
		if (tag_s2.k == 2'd3)
			term = {{(SUM_W-COEF_W){tag_s2.coef[COEF_W-1]}}, tag_s2.coef} <<< FRAC_BITS;
		else
			term = (p_mx > p_mn) ? p_mx : p_mn;
	end

	always_ff @(posedge clk) begin
		term_s3 <= term;
		nz_s3   <= (tag_s2.k != 2'd3) && (tag_s2.coef != '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
			tag_s3 <= '0;
		end else begin
			tag_s2 <= tag_s1;
			tag_s3 <= tag_s2;
		end
	end

	always_comb begin
		sum    = ((tag_s3.k == 2'd0) ? '0 : acc_q) + term_s3;
		nz_sum = ((tag_s3.k == 2'd0) ? 1'b0 : nz_q) | nz_s3;
	end

	always_ff @(posedge clk) begin
		if (tag_s3.valid) begin
			acc_q <= sum;
			nz_q  <= nz_sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res <= '0;
		end else begin
			res.valid  <= tag_s3.valid && (tag_s3.k == 2'd3);
			res.last   <= tag_s3.last;
			res.culled <= nz_sum && (sum <= 0);
		end
	end

`ifndef SYNTHESIS
	a_res_needs_d: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> $past(tag_s3.valid) && $past(tag_s3.k) == 2'd3)
		else $error("plane result without its d coefficient");
	a_last_is_d: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s1.valid && tag_s1.last |-> tag_s1.k == 2'd3)
		else $error("last coefficient is not a d term");
	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		tag_s3.valid && tag_s3.k != 2'd0 |-> $past(tag_s3.valid))
		else $error("coefficient sequence broken in pipeline");
`endif

endmodule
`default_nettype wire

### sv/frustum_box_culler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// frustum_box_culler
// View frustum culling of axis-aligned boxes with fixed-point planes.
// ----------------------------------------------------------------------------
// loads are written while idle and leave the block idle; plane extraction keeps
// the block busy after its transfer for 4 rows of 16 mac reads, a drain and 6
// plane writes, bounded by the single read port of each matrix memory; a box
// test reads 24 coefficients from the plane memory (one coefficient per cycle),
// lets the distance pipe drain and then loads the result register, after which
// the block takes the next item; a stalled result adds its stall.
// one item is worked on at a time; the result register frees the input side.
// reset clears all stores through valid bits: every box reads as visible.
module frustum_box_culler #(
	parameter int FRAC_BITS = fbc_pkg::FRAC_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	fbc_in_if.sink     item,
	fbc_out_if.source  result
);
	import fbc_pkg::*;

	state_t state_q, state_d;

	logic signed [ELEM_W-1:0]   mv_mem [MAT_DEPTH];
	logic signed [ELEM_W-1:0]   pj_mem [MAT_DEPTH];
	logic [PSTORE_W-1:0]        pm_mem [PLANE_COEFFS];
	logic [MAT_DEPTH-1:0]       mv_vld_q, pj_vld_q;
	logic [PLANE_COEFFS-1:0]    pm_vld_q;

	logic [3:0]                 mv_raddr, pj_raddr;
	logic signed [ELEM_W-1:0]   mv_rd_s1, pj_rd_s1;
	logic                       mv_rv_s1, pj_rv_s1;
	logic [PSTORE_W-1:0]        pm_rd_s1;
	logic                       pm_rv_s1;

	logic                       fire;
	op_t                        op;

	logic [1:0]                 row_q;
	logic [3:0]                 iss_q;
	logic [2:0]                 pl_q;
	logic                       drain_q;
	logic [4:0]                 bx_q;

	ex_tag_t                    ex_s1, ex_s2;
	logic signed [63:0]         prod_s2;
	logic signed [ACC_W-1:0]    acc_q, acc_sum;
	logic signed [CLIP_W-1:0]   clip_q [4];
	logic signed [COEF_W-1:0]   w_ext, e_ext, pl_val;
	logic [4:0]                 pm_waddr;

	box_t                       box_q;
	coef_tag_t                  coef_s1;
	logic                       coef_vld_s1;
	logic [1:0]                 coef_k_s1;
	logic                       bx_last_s1;
	plane_res_t                 res;
	logic                       culled_q;
	logic                       ov_q, vis_q;

	assign op   = op_t'(item.op);
	assign fire = item.valid && item.ready;
	assign item.ready = (state_q == ST_IDLE);

	// matrix memories
	assign mv_raddr = {row_q, iss_q[1:0]};
	assign pj_raddr = {iss_q[1:0], iss_q[3:2]};

	always_ff @(posedge clk) begin
		if (fire && op == OP_LOAD_MV) mv_mem[item.elem_index] <= item.elem_value;
		if (fire && op == OP_LOAD_PJ) pj_mem[item.elem_index] <= item.elem_value;
		mv_rd_s1 <= mv_mem[mv_raddr];
		pj_rd_s1 <= pj_mem[pj_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_vld_q <= '0;
			pj_vld_q <= '0;
			mv_rv_s1 <= 1'b0;
			pj_rv_s1 <= 1'b0;
		end else begin
			if (fire && op == OP_LOAD_MV) mv_vld_q[item.elem_index] <= 1'b1;
			if (fire && op == OP_LOAD_PJ) pj_vld_q[item.elem_index] <= 1'b1;
			mv_rv_s1 <= mv_vld_q[mv_raddr];
			pj_rv_s1 <= pj_vld_q[pj_raddr];
		end
	end

	// clip element multiply-accumulate
	always_ff @(posedge clk) begin
		prod_s2 <= (mv_rv_s1 ? mv_rd_s1 : $signed(ELEM_W'(0)))
			* (pj_rv_s1 ? pj_rd_s1 : $signed(ELEM_W'(0)));
	end

	assign acc_sum = ((ex_s2.k == 2'd0) ? '0 : acc_q) + {{(ACC_W-64){prod_s2[63]}}, prod_s2};

	always_ff @(posedge clk) begin
		if (ex_s2.valid) begin
			acc_q <= acc_sum;
			if (ex_s2.k == 2'd3) clip_q[ex_s2.c] <= sat_clip(acc_sum >>> FRAC_BITS);
		end
	end

	// plane coefficient for plane pl_q, row row_q
	always_comb begin
		w_ext = {clip_q[3][CLIP_W-1], clip_q[3]};
		e_ext = {clip_q[plane_col(pl_q)][CLIP_W-1], clip_q[plane_col(pl_q)]};
		pl_val = plane_add(pl_q) ? (w_ext + e_ext) : (w_ext - e_ext);
		pm_waddr = {pl_q, row_q};
	end

	// plane memory
	always_ff @(posedge clk) begin
		if (state_q == ST_EX_WRITE) pm_mem[pm_waddr] <= {pl_val[COEF_W-1], pl_val};
		pm_rd_s1 <= pm_mem[bx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_vld_q    <= '0;
			pm_rv_s1    <= 1'b0;
			ex_s1       <= '0;
			ex_s2       <= '0;
			coef_vld_s1 <= 1'b0;
			coef_k_s1   <= '0;
			bx_last_s1  <= 1'b0;
		end else begin
			if (state_q == ST_EX_WRITE) pm_vld_q[pm_waddr] <= 1'b1;
			pm_rv_s1      <= pm_vld_q[bx_q];
			ex_s1.valid   <= (state_q == ST_EX_RUN);
			ex_s1.c       <= iss_q[3:2];
			ex_s1.k       <= iss_q[1:0];
			ex_s2         <= ex_s1;
			coef_vld_s1   <= (state_q == ST_BOX_RUN);
			coef_k_s1     <= bx_q[1:0];
			bx_last_s1    <= (bx_q == 5'(PLANE_COEFFS - 1));
		end
	end

	always_comb begin
		coef_s1.valid = coef_vld_s1;
		coef_s1.k     = coef_k_s1;
		coef_s1.last  = bx_last_s1;
		coef_s1.coef  = pm_rv_s1 ? pm_rd_s1[COEF_W-1:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (fire && op == OP_TEST) begin
			box_q.x_min <= item.box_x_min;
			box_q.y_min <= item.box_y_min;
			box_q.z_min <= item.box_z_min;
			box_q.x_max <= item.box_x_max;
			box_q.y_max <= item.box_y_max;
			box_q.z_max <= item.box_z_max;
		end
	end

	fbc_box_mac #(.FRAC_BITS(FRAC_BITS)) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.tag_s1 (coef_s1),
		.box    (box_q),
		.res    (res)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (fire && op == OP_EXTRACT) state_d = ST_EX_RUN;
				else if (fire && op == OP_TEST) state_d = ST_BOX_RUN;
			end
			ST_EX_RUN:   if (iss_q == 4'hF) state_d = ST_EX_DRAIN;
			ST_EX_DRAIN: if (drain_q) state_d = ST_EX_WRITE;
			ST_EX_WRITE: begin
				if (pl_q == 3'(NUM_PLANES - 1))
					state_d = (row_q == 2'd3) ? ST_IDLE : ST_EX_RUN;
			end
			ST_BOX_RUN:  if (bx_q == 5'(PLANE_COEFFS - 1)) state_d = ST_BOX_DRAIN;
			ST_BOX_DRAIN: if (res.valid && res.last) state_d = ST_BOX_DONE;
			ST_BOX_DONE: if (!ov_q || result.ready) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			iss_q    <= '0;
			pl_q     <= '0;
			drain_q  <= 1'b0;
			bx_q     <= '0;
			culled_q <= 1'b0;
			ov_q     <= 1'b0;
			vis_q    <= 1'b0;
		end else begin
			if (state_q == ST_IDLE) begin
				row_q <= '0;
				iss_q <= '0;
				pl_q  <= '0;
				bx_q  <= '0;
			end
			if (state_q == ST_EX_RUN) iss_q <= iss_q + 4'd1;
			drain_q <= (state_q == ST_EX_DRAIN) && !drain_q;
			if (state_q == ST_EX_WRITE) begin
				if (pl_q == 3'(NUM_PLANES - 1)) begin
					pl_q  <= '0;
					row_q <= row_q + 2'd1;
				end else begin
					pl_q <= pl_q + 3'd1;
				end
			end
			if (state_q == ST_BOX_RUN)
				bx_q <= (bx_q == 5'(PLANE_COEFFS - 1)) ? '0 : bx_q + 5'd1;
			if (fire && op == OP_TEST) culled_q <= 1'b0;
			else if (res.valid && res.culled) culled_q <= 1'b1;
			// result register, loaded when free or being drained
			if (state_q == ST_BOX_DONE && (!ov_q || result.ready)) begin
				ov_q  <= 1'b1;
				vis_q <= !culled_q;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
		end
	end

	assign result.valid   = ov_q;
	assign result.visible = vis_q;

`ifndef SYNTHESIS
	a_last_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.last |-> state_q == ST_BOX_DRAIN)
		else $error("box result arrived outside drain");
	a_ex_tag_state: assert property (@(posedge clk) disable iff (!arst_n)
		ex_s1.valid |-> state_q == ST_EX_RUN || state_q == ST_EX_DRAIN)
		else $error("clip mac active outside extraction");
	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(state_q) == ST_BOX_DONE)
		else $error("result raised without finished box test");
	a_plane_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EX_WRITE |-> pl_q < 3'(NUM_PLANES))
		else $error("plane counter out of range");
`endif

endmodule
`default_nettype wire
